>>> rtl/core/mpmf_pkg.sv
// shared types and constants of the min pooling and min filter block
package mpmf_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned PixW   = 16;
  localparam int unsigned AddrW  = 2 * CoordW;
  localparam int unsigned CfgW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OffW   = 4;

  localparam logic [CfgIdxW-1:0] CFG_POOL_SHIFT    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_RADIUS = 1'd1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] POOL_SHIFT_RST    = 2'd1;
  localparam logic [2:0] WINDOW_RADIUS_RST = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_RD_RUN,
    ST_RD_DRAIN,
    ST_RD_DONE
  } mpmf_state_e;

endpackage

>>> rtl/core/min_pool_then_min_filter.sv
// top level: pooled minimum store with a windowed minimum read-out
// Pixel writes fold into a 256 x 256 pooled store held in one synchronous
// single-port memory; each write goes through accept, read and write
// back. A read of a pooled cell walks the (2r+1) x (2r+1) window, one
// memory read per cycle (r is 1 after reset, up to 7); a read outside
// the output area skips the walk. The result waits in an output register,
// and the next transaction is taken as soon as it has been loaded there.
// The store has no reset and no clearing pass: a cell must be written
// before it is read.
module min_pool_then_min_filter #(
  parameter int unsigned IMG_SIZE = 256,
  parameter int unsigned PIX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mpmf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mpmf_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [mpmf_pkg::CoordW-1:0]         col_i,
  input  logic [mpmf_pkg::CoordW-1:0]         row_i,
  input  logic signed [mpmf_pkg::PixW-1:0]    sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mpmf_pkg::PixW-1:0]    min_value_o,
  output logic                                bad_coord_o
);
  import mpmf_pkg::*;

  localparam int unsigned WBits = $clog2(IMG_SIZE + 1);
  localparam int unsigned CW    = (WBits > 9) ? WBits : 9;
  localparam logic signed [PixW-1:0] PixMax =
    (PIX_BITS >= 16) ? 16'sh7FFF : PixW'((64'sd1 <<< (PIX_BITS - 1)) - 64'sd1);
  localparam logic signed [PixW-1:0] PixMin = -PixMax - 16'sd1;
  localparam logic signed [PixW-1:0] BestInit = 16'sh7FFF;

  mpmf_state_e state_q, state_d;

  logic [1:0] pool_shift_q;
  logic [2:0] window_radius_q;

  logic [CoordW-1:0]         col_q, row_q;
  logic signed [PixW-1:0]    samp_q;
  logic                      first_q, skip_q;
  logic [AddrW-1:0]          idx_q;
  logic signed [OffW-1:0]    dy_q, dy_d, dx_q, dx_d;
  logic signed [PixW-1:0]    best_q, best_d;
  logic                      rd_vld_q;
  logic                      bad_q;
  logic                      out_vld_q;
  logic signed [PixW-1:0]    out_min_q;
  logic                      out_bad_q;

  logic signed [PixW-1:0] mem [2**AddrW];
  logic signed [PixW-1:0] rdata_q;
  logic                   mem_re, mem_we;
  logic [AddrW-1:0]       mem_addr;
  logic signed [PixW-1:0] mem_wdata;

  logic [CW-1:0]          w_full;
  logic [CoordW-1:0]      lim;
  logic                   accept, out_free, last_tap, rd_bad;
  logic [CoordW-1:0]      pc, pr, blk_mask;
  logic signed [PixW-1:0] samp_sat;
  logic signed [OffW-1:0] r_pos, r_neg;
  logic signed [9:0]      ysum, xsum;
  logic [CoordW-1:0]      yy, xx;

  // geometry
  always_comb begin
    w_full   = CW'(IMG_SIZE) >> pool_shift_q;
    lim      = (w_full >= CW'(256)) ? 8'hFF : CoordW'(w_full - CW'(1));
    pc       = col_i >> pool_shift_q;
    pr       = row_i >> pool_shift_q;
    blk_mask = (8'd1 << pool_shift_q) - 8'd1;
    rd_bad   = (CW'(col_i) >= w_full) || (CW'(row_i) >= (w_full >> 1));
    if (sample_i > PixMax) begin
      samp_sat = PixMax;
    end else if (sample_i < PixMin) begin
      samp_sat = PixMin;
    end else begin
      samp_sat = sample_i;
    end
    r_pos = OffW'(window_radius_q);
    r_neg = -r_pos;
  end

  // window tap address with edge clamp
  always_comb begin
    ysum = $signed({2'b00, row_q}) + 10'(dy_q);
    xsum = $signed({2'b00, col_q}) + 10'(dx_q);
    if (ysum[9]) begin
      yy = '0;
    end else if (ysum[8:0] > {1'b0, lim}) begin
      yy = lim;
    end else begin
      yy = ysum[7:0];
    end
    if (xsum[9]) begin
      xx = '0;
    end else if (xsum[8:0] > {1'b0, lim}) begin
      xx = lim;
    end else begin
      xx = xsum[7:0];
    end
    last_tap = (dy_q == r_pos) && (dx_q == r_pos);
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_WRITE) begin
            state_d = ST_WR_RD;
          end else if (rd_bad) begin
            state_d = ST_RD_DONE;
          end else begin
            state_d = ST_RD_RUN;
          end
        end
      end
      ST_WR_RD:    state_d = ST_WR_WB;
      ST_WR_WB:    state_d = ST_IDLE;
      ST_RD_RUN: begin
        if (last_tap) state_d = ST_RD_DRAIN;
      end
      ST_RD_DRAIN: state_d = ST_RD_DONE;
      ST_RD_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = idx_q;
    mem_wdata  = samp_q;
    dy_d       = dy_q;
    dx_d       = dx_q;
    best_d     = best_q;
    if (rd_vld_q && (rdata_q < best_q)) best_d = rdata_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        dy_d       = r_neg;
        dx_d       = r_neg;
        best_d     = BestInit;
      end
      ST_WR_RD: begin
        mem_re = 1'b1;
      end
      ST_WR_WB: begin
        mem_we = !skip_q;
        if (!first_q && (rdata_q < samp_q)) mem_wdata = rdata_q;
      end
      ST_RD_RUN: begin
        mem_re   = 1'b1;
        mem_addr = {yy, xx};
        if (dx_q == r_pos) begin
          dx_d = r_neg;
          dy_d = dy_q + 4'sd1;
        end else begin
          dx_d = dx_q + 4'sd1;
        end
      end
      ST_RD_DRAIN: ;
      ST_RD_DONE:  ;
      default:     ;
    endcase
  end

  // pooled store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pool_shift_q    <= POOL_SHIFT_RST;
      window_radius_q <= WINDOW_RADIUS_RST;
      rd_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_RD_RUN);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_SHIFT:    pool_shift_q    <= cfg_wdata_i[1:0];
          CFG_WINDOW_RADIUS: window_radius_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == ST_RD_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // transaction payload and window registers
  always_ff @(posedge clk_i) begin
    dy_q   <= dy_d;
    dx_q   <= dx_d;
    best_q <= best_d;
    if (accept) begin
      col_q   <= col_i;
      row_q   <= row_i;
      samp_q  <= samp_sat;
      first_q <= ((col_i & blk_mask) == '0) && ((row_i & blk_mask) == '0);
      skip_q  <= (CW'(col_i) >= CW'(IMG_SIZE)) || (CW'(row_i) >= CW'(IMG_SIZE)) ||
                 (CW'(pc) >= w_full) || (CW'(pr) >= w_full);
      idx_q   <= {pr, pc};
      bad_q   <= rd_bad;
    end
    if (state_q == ST_RD_DONE && out_free) begin
      out_min_q <= bad_q ? '0 : best_q;
      out_bad_q <= bad_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign min_value_o = out_min_q;
  assign bad_coord_o = out_bad_q;

  a_wb_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_WB) |-> $past(state_q == ST_WR_RD))
    else $error("write back without a preceding read");

  a_tap_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_RD_RUN))
    else $error("tap data valid outside the window walk");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_RD_DONE))
    else $error("result raised without a finished read");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_bad_q) |-> (out_min_q == '0))
    else $error("flagged result carries a non-zero minimum");

endmodule

>>> sim/tb_top.sv
// testbench for the min pooling and min filter block with its own pooled store prediction
module tb_top;
  import mpmf_pkg::*;

  localparam int unsigned ImgSize    = 256;
  localparam int unsigned StoreSide  = 256;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned SettleCyc  = 16;
  localparam int unsigned DrainCyc   = 40;

  typedef struct packed {
    logic signed [PixW-1:0] min_value;
    logic                   bad_coord;
  } window_min_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx   = CFG_POOL_SHIFT;
  logic [CfgW-1:0]           cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      req_type  = REQ_WRITE;
  logic [CoordW-1:0]         col       = '0;
  logic [CoordW-1:0]         row       = '0;
  logic signed [PixW-1:0]    sample    = '0;
  logic                      out_stall = 1'b0;
  wire                       in_stall;
  wire                       out_valid;
  wire signed [PixW-1:0]     min_value;
  wire                       bad_coord;

  logic signed [PixW-1:0]    cell_value [StoreSide*StoreSide];
  bit                        cell_written [StoreSide*StoreSide];
  int unsigned               cur_shift  = POOL_SHIFT_RST;
  int unsigned               cur_radius = WINDOW_RADIUS_RST;
  window_min_t               pending_minima [$];
  int unsigned               errors     = 0;
  int unsigned               cycles     = 0;
  int unsigned               items_sent = 0;
  int unsigned               stall_left = 0;
  bit                        quiet      = 1'b0;

  min_pool_then_min_filter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .col_i       (col),
    .row_i       (row),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .min_value_o (min_value),
    .bad_coord_o (bad_coord)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int clampi(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [PixW-1:0] rand_sample();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 16'sh8000;
    if (p < 20) return 16'sh7fff;
    return PixW'($urandom);
  endfunction

  // folds a pixel into the pooled store or works out a window minimum
  function automatic bit pool_and_filter(input logic req, input logic [CoordW-1:0] px_col,
                                         input logic [CoordW-1:0] px_row,
                                         input logic signed [PixW-1:0] px_val,
                                         output window_min_t res);
    int unsigned w, mask, pc, pr, idx;
    int best, lim, rad, yy, xx;
    w = ImgSize >> cur_shift;
    res = '0;
    if (req == REQ_WRITE) begin
      pc = px_col >> cur_shift;
      pr = px_row >> cur_shift;
      if (pc >= w || pr >= w) return 1'b0;
      mask = (1 << cur_shift) - 1;
      idx = pr * StoreSide + pc;
      if ((px_col & mask) == 0 && (px_row & mask) == 0) begin
        cell_value[idx] = px_val;
        cell_written[idx] = 1'b1;
      end else if (px_val < cell_value[idx]) begin
        cell_value[idx] = px_val;
      end
      return 1'b0;
    end
    if (px_col >= w || px_row >= w / 2) begin
      res.bad_coord = 1'b1;
      return 1'b1;
    end
    lim = ((w < StoreSide) ? w : StoreSide) - 1;
    rad = cur_radius;
    best = 32'sh7fffffff;
    for (int dy = -rad; dy <= rad; dy++) begin
      yy = clampi(int'(px_row) + dy, 0, lim);
      for (int dx = -rad; dx <= rad; dx++) begin
        xx = clampi(int'(px_col) + dx, 0, lim);
        if (cell_value[yy * StoreSide + xx] < best) best = cell_value[yy * StoreSide + xx];
      end
    end
    res.min_value = best[PixW-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 50) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic send_request(input logic req, input logic [CoordW-1:0] c,
                              input logic [CoordW-1:0] r, input logic signed [PixW-1:0] s);
    int unsigned gap;
    window_min_t res;
    gap = (quiet || $urandom_range(0, 1)) ? 0 : pick_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    col      <= c;
    row      <= r;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pool_and_filter(req, c, r, s, res)) pending_minima.push_back(res);
    items_sent++;
  endtask

  // an unwritten cell always takes the first pixel of its block
  task automatic send_to_cell(input int unsigned pc, input int unsigned pr, input bit first,
                              input logic signed [PixW-1:0] s);
    int unsigned mask, ox, oy;
    mask = (1 << cur_shift) - 1;
    ox = 0;
    oy = 0;
    if (!cell_written[pr * StoreSide + pc]) first = 1'b1;
    if (!first && mask != 0) begin
      ox = $urandom_range(0, mask);
      oy = $urandom_range(0, mask);
      if (ox == 0 && oy == 0) ox = $urandom_range(1, mask);
    end
    send_request(REQ_WRITE, 8'((pc << cur_shift) | ox), 8'((pr << cur_shift) | oy), s);
  endtask

  // fills any unwritten cell of the window before the read
  task automatic read_cell(input int unsigned c, input int unsigned r);
    int unsigned w;
    int lim, rad, yy, xx;
    w = ImgSize >> cur_shift;
    lim = w - 1;
    rad = cur_radius;
    if (c < w && r < w / 2) begin
      for (int dy = -rad; dy <= rad; dy++) begin
        yy = clampi(int'(r) + dy, 0, lim);
        for (int dx = -rad; dx <= rad; dx++) begin
          xx = clampi(int'(c) + dx, 0, lim);
          if (!cell_written[yy * StoreSide + xx]) send_to_cell(xx, yy, 1'b1, rand_sample());
        end
      end
    end
    send_request(REQ_READ, 8'(c), 8'(r), PixW'($urandom));
  endtask

  task automatic set_config(input logic [CfgW-1:0] shift_val, input logic [CfgW-1:0] rad_val);
    in_valid <= 1'b0;
    while (pending_minima.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_POOL_SHIFT;
    cfg_wdata <= shift_val;
    @(posedge clk);
    cur_shift = shift_val & 3;
    cfg_idx   <= CFG_WINDOW_RADIUS;
    cfg_wdata <= rad_val;
    @(posedge clk);
    cur_radius = rad_val;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    window_min_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_minima.size() == 0) begin
        report_mismatch("result with no read waiting");
      end else begin
        head = pending_minima.pop_front();
        if (min_value !== head.min_value)
          report_mismatch($sformatf("min_value %0d, predicted %0d", min_value, head.min_value));
        if (bad_coord !== head.bad_coord)
          report_mismatch($sformatf("bad_coord %0b, predicted %0b", bad_coord, head.bad_coord));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < 30) stall_left = pick_len();
    end
  end

  // register values after reset, extreme samples
  task automatic test_reset_config();
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        if (x == 2 && y == 2) send_to_cell(x, y, 1'b1, 16'sh8000);
        else if (x == 0 && y == 0) send_to_cell(x, y, 1'b1, 16'sh7fff);
        else send_to_cell(x, y, 1'b1, rand_sample());
      end
    end
    read_cell(0, 0);
    read_cell(1, 1);
  endtask

  // other pixels of a block before its first pixel
  task automatic test_block_order();
    send_to_cell(1, 1, 1'b0, -16'sd7);
    send_to_cell(1, 1, 1'b1, 16'sd300);
    read_cell(1, 0);
    send_to_cell(0, 0, 1'b0, 16'sh8000);
    read_cell(0, 0);
  endtask

  // reads outside the output area, upper pool shift bit dropped
  task automatic test_bad_coord();
    set_config(3'b101, 3'd0);
    read_cell(128, 0);
    read_cell(0, 64);
    read_cell(255, 255);
    read_cell(127, 63);
    read_cell(0, 0);
  endtask

  task automatic test_corners();
    set_config(3'd0, 3'd0);
    read_cell(255, 127);
    set_config(3'd3, 3'd0);
    read_cell(31, 15);
    read_cell(32, 0);
  endtask

  task automatic test_random();
    int unsigned w, start, kind;
    int cx, cy, spread, c, r;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: set_config(3'd3, 3'd7);
        1: set_config(3'd0, 3'd0);
        2: set_config(3'd0, 3'd7);
        3: set_config(3'd3, 3'd0);
        default: set_config(3'($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7))
                                                        : 3'($urandom_range(0, 2)));
      endcase
      quiet = (phase == 3 || phase == 6);
      w = ImgSize >> cur_shift;
      spread = (cur_radius >= 4) ? 1 : 3;
      cx = $urandom_range(0, w - 1);
      cy = $urandom_range(0, w / 2 - 1);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          if ($urandom_range(0, 9) == 0) begin
            c = $urandom_range(0, 1) ? w - 1 : 0;
            r = $urandom_range(0, 1) ? w / 2 - 1 : 0;
          end else begin
            c = clampi(cx + int'($urandom_range(0, 2 * spread)) - spread, 0, w - 1);
            r = clampi(cy + int'($urandom_range(0, 2 * spread)) - spread, 0, w / 2 - 1);
          end
          read_cell(c, r);
        end else if (kind < 45) begin
          if (w == ImgSize || $urandom_range(0, 1)) begin
            c = $urandom_range(0, 255);
            r = $urandom_range(w / 2, 255);
          end else begin
            c = $urandom_range(w, 255);
            r = $urandom_range(0, 255);
          end
          read_cell(c, r);
        end else if (kind < 95) begin
          c = clampi(cx + int'($urandom_range(0, 2 * (spread + cur_radius)))
                     - spread - int'(cur_radius), 0, w - 1);
          r = clampi(cy + int'($urandom_range(0, 2 * (spread + cur_radius)))
                     - spread - int'(cur_radius), 0, w - 1);
          send_to_cell(c, r, kind >= 75, rand_sample());
        end else begin
          send_to_cell($urandom_range(0, w - 1), $urandom_range(0, w - 1),
                       1'($urandom_range(0, 1)), rand_sample());
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_block_order();
    test_bad_coord();
    test_corners();
    test_random();
    in_valid <= 1'b0;
    while (pending_minima.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
